>>> hw/rtl/sfd_pkg.sv
// Shared types and constants for the sum-checked frame deframer.
package sfd_pkg;

   // Frame overhead: two header bytes, the length byte and the checksum byte
   localparam logic [7:0] FRAME_OVERHEAD = 8'd4;

   // Reset values of the header registers
   localparam logic [7:0] HEADER_FIRST_RESET  = 8'hAA;
   localparam logic [7:0] HEADER_SECOND_RESET = 8'h55;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEADER_FIRST  = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEADER_SECOND = 8'd1;

   // Parser phases, one-hot
   typedef enum logic [4:0] {
      PH_HUNT = 5'b00001,
      PH_HDR2 = 5'b00010,
      PH_LEN  = 5'b00100,
      PH_DATA = 5'b01000,
      PH_SUM  = 5'b10000
   } phase_type;

   // Input word
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       burst_end;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       payload_valid;
      logic       frame_done;
      logic       frame_good;
      logic [7:0] payload_count;
   } rsp_word_type;

   // Result word handed from the parser to the output buffer
   typedef struct packed {
      logic         push;
      rsp_word_type word;
   } push_type;

endpackage

>>> hw/rtl/sum_checked_frame_deframer_unit.sv
// Top level of the sum-checked frame deframer.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+--------------------------------
//  req     | in        | req_valid/req_ready  | rx_byte, burst_end
//  rsp     | out       | rsp_valid/rsp_ready  | payload byte, frame done/good, count
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One word per cycle while the output buffer has space: the parser state
// machine works each byte in the cycle it is accepted and its result is
// registered in a two-entry output buffer. req_ready drops only while both
// buffer entries hold unread results. Synchronous reset returns the parser to
// header hunt, empties the buffer and loads the headers 0xAA and 0x55.
// csr_ready is always high.
module sum_checked_frame_deframer_unit import sfd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_word_type               req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_word_type               rsp_word,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]                 csr_wdata
);

   logic [7:0] header_first_ff;
   logic [7:0] header_second_ff;
   logic       space;
   logic       take;
   push_type   result;

   assign csr_ready = 1'b1;
   assign req_ready = space;
   assign take      = req_valid && space;

   // Header registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= HEADER_FIRST_RESET;
         header_second_ff <= HEADER_SECOND_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_HEADER_FIRST:  header_first_ff  <= csr_wdata;
            CSR_HEADER_SECOND: header_second_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   sfd_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .req_word      (req_word),
      .header_first  (header_first_ff),
      .header_second (header_second_ff),
      .result        (result)
   );

   sfd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

>>> hw/rtl/sfd_parse.sv
// Frame parser: header hunt, length, payload and checksum tracking.
module sfd_parse import sfd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         take,
   input  req_word_type req_word,
   input  logic [7:0]   header_first,
   input  logic [7:0]   header_second,
   output push_type     result
);

   phase_type  phase_ff, phase_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] seen_ff, seen_in;
   logic [7:0] sum_ff, sum_in;

   logic [7:0] rx;
   logic       pv, done, good;
   logic [7:0] count;

   assign rx = req_word.rx_byte;

   // Next state and result for the word on the input
   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      seen_in   = seen_ff;
      sum_in    = sum_ff;
      pv        = 1'b0;
      done      = 1'b0;
      good      = 1'b0;
      count     = 8'd0;

      case (phase_ff)
         PH_HDR2: begin
            if (rx == header_second) begin
               sum_in   = sum_ff + rx;
               phase_in = PH_LEN;
            end else if (rx == header_first) begin
               // repeated first header byte restarts the match
               sum_in = rx;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_LEN: begin
            length_in = rx;
            sum_in    = sum_ff + rx;
            seen_in   = 8'd0;
            if (rx < FRAME_OVERHEAD) begin
               done     = 1'b1;
               phase_in = PH_HUNT;
            end else if (rx == FRAME_OVERHEAD) begin
               phase_in = PH_SUM;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            pv      = 1'b1;
            sum_in  = sum_ff + rx;
            seen_in = seen_ff + 8'd1;
            if (seen_in == length_ff - FRAME_OVERHEAD) begin
               phase_in = PH_SUM;
            end
         end
         PH_SUM: begin
            done     = 1'b1;
            good     = (rx == sum_ff);
            count    = seen_ff;
            phase_in = PH_HUNT;
         end
         default: begin
            if (rx == header_first) begin
               sum_in   = rx;
               phase_in = PH_HDR2;
            end else begin
               phase_in = PH_HUNT;
            end
         end
      endcase

      // burst end drops any frame open past its header
      if (req_word.burst_end) begin
         if (phase_in inside {PH_LEN, PH_DATA, PH_SUM}) begin
            done  = 1'b1;
            good  = 1'b0;
            count = seen_in;
         end
         phase_in = PH_HUNT;
      end
   end

   assign result.push               = take && (pv || done);
   assign result.word.payload_byte  = pv ? rx : 8'd0;
   assign result.word.payload_valid = pv;
   assign result.word.frame_done    = done;
   assign result.word.frame_good    = good;
   assign result.word.payload_count = count;

   // State registers, advanced on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         length_ff <= 8'd0;
         seen_ff   <= 8'd0;
         sum_ff    <= 8'd0;
      end else if (take) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         seen_ff   <= seen_in;
         sum_ff    <= sum_in;
      end
   end

endmodule

>>> hw/rtl/sfd_skid.sv
// Two-entry result buffer between the parser and the result channel.
module sfd_skid import sfd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  push_type     result,
   output logic         space,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   rsp_word_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign space     = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_word  = slot_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = result.push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, result.push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage
   always_ff @(posedge clock) begin
      if (result.push) begin
         slot_ff[wr_ptr_ff] <= result.word;
      end
   end

endmodule

>>> hw/rtl/sfd_checker.sv
// Port-level checks for the deframer, bound to the top level.
module sfd_checker import sfd_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input req_word_type               req_word,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input rsp_word_type               rsp_word,
   input logic                       csr_valid,
   input logic                       csr_ready,
   input logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input logic [7:0]                 csr_wdata
);

   // Nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result changed");

   // Every result carries a payload byte or a frame end
   a_rsp_content: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.payload_valid || rsp_word.frame_done))
      else $error("empty result word");

   // Verdict and count only with frame end, byte only with payload flag
   a_rsp_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_word.frame_done || (!rsp_word.frame_good &&
                      rsp_word.payload_count == 8'd0)) &&
                     (rsp_word.payload_valid || rsp_word.payload_byte == 8'd0)))
      else $error("result fields inconsistent");

   // Back-pressure only while results are waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

endmodule

bind sum_checked_frame_deframer_unit sfd_checker u_checker (.*);

>>> dv/tb.sv
// Testbench for the sum-checked frame deframer: directed and random byte streams against a predictor.
`timescale 1ns / 100ps

module tb;
   import sfd_pkg::*;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   req_word_type               req_word;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_word_type               rsp_word;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [7:0]                 csr_wdata;

   // Predictor copy of the parser and header registers
   logic [7:0]   hdr_first;
   logic [7:0]   hdr_second;
   phase_type    parse_ph;
   logic [7:0]   frame_len;
   logic [7:0]   payload_seen;
   logic [7:0]   sum_acc;

   rsp_word_type expected_words[$];
   bit           jitter_on;
   int           mismatches;
   int           bytes_sent;
   int           frame_bytes;
   int           words_seen;
   int           good_frames;
   int           bad_frames;

   sum_checked_frame_deframer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // Result side drops rsp_ready with a chance of about one in five while jitter is on
   always @(posedge clock) begin
      rsp_ready <= !jitter_on || ($urandom_range(99) >= 20);
   end

   // Work one received byte through the parser; returns 1 when a word results
   function automatic bit deframe_byte(input req_word_type w, output rsp_word_type r);
      logic [7:0] b;
      bit         done;
      b    = w.rx_byte;
      done = 1'b0;
      r    = '0;
      case (parse_ph)
         PH_HDR2: begin
            if (b == hdr_second) begin
               sum_acc  = sum_acc + b;
               parse_ph = PH_LEN;
            end else if (b == hdr_first) begin
               // repeated first header byte restarts the match here
               sum_acc = b;
            end else begin
               parse_ph = PH_HUNT;
            end
         end
         PH_LEN: begin
            frame_len    = b;
            sum_acc      = sum_acc + b;
            payload_seen = '0;
            if (b < FRAME_OVERHEAD) begin
               done     = 1'b1;
               parse_ph = PH_HUNT;
            end else if (b == FRAME_OVERHEAD) begin
               parse_ph = PH_SUM;
            end else begin
               parse_ph = PH_DATA;
            end
         end
         PH_DATA: begin
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            sum_acc         = sum_acc + b;
            payload_seen    = payload_seen + 8'd1;
            if (payload_seen == frame_len - FRAME_OVERHEAD) parse_ph = PH_SUM;
         end
         PH_SUM: begin
            done            = 1'b1;
            r.frame_good    = (b == sum_acc);
            r.payload_count = payload_seen;
            parse_ph        = PH_HUNT;
         end
         default: begin
            if (b == hdr_first) begin
               sum_acc  = b;
               parse_ph = PH_HDR2;
            end else begin
               parse_ph = PH_HUNT;
            end
         end
      endcase
      // burst end drops an open frame; a lone first header byte goes silently
      if (w.burst_end) begin
         if (parse_ph == PH_LEN || parse_ph == PH_DATA || parse_ph == PH_SUM) begin
            done            = 1'b1;
            r.frame_good    = 1'b0;
            r.payload_count = payload_seen;
         end
         parse_ph = PH_HUNT;
      end
      r.frame_done = done;
      return r.payload_valid || done;
   endfunction

   // Send one word; the prediction is queued when it is accepted
   task automatic send_byte(input logic [7:0] b, input logic last);
      req_word_type w;
      rsp_word_type r;
      w.rx_byte   = b;
      w.burst_end = last;
      if (jitter_on && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (deframe_byte(w, r)) expected_words.push_back(r);
   endtask

   // Build a frame for the current headers; burst end on byte cut_at, fill < 0 = random
   task automatic send_frame(input logic [7:0] len, input bit bad_sum, input int cut_at,
                             input int fill);
      logic [7:0] frame_q[$];
      logic [7:0] chk;
      frame_q = {hdr_first, hdr_second, len};
      if (len >= FRAME_OVERHEAD) begin
         for (int i = 0; i < len - FRAME_OVERHEAD; i++)
            frame_q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
         chk = '0;
         foreach (frame_q[i]) chk += frame_q[i];
         if (bad_sum) chk ^= 8'($urandom_range(1, 255));
         frame_q.push_back(chk);
      end
      foreach (frame_q[i]) begin
         frame_bytes++;
         send_byte(frame_q[i], i == cut_at);
         if (i == cut_at) break;
      end
   endtask

   // Hold off the sender until every expected word is back, then let the buffer settle
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write both header registers; only called while the block is idle
   task automatic load_headers(input logic [7:0] first, input logic [7:0] second);
      logic [CSR_INDEX_WIDTH-1:0] idx[2];
      logic [7:0]                 val[2];
      idx = '{CSR_HEADER_FIRST, CSR_HEADER_SECOND};
      val = '{first, second};
      for (int i = 0; i < 2; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         do @(posedge clock); while (!csr_ready);
         if (idx[i] == CSR_HEADER_FIRST) hdr_first = val[i];
         else hdr_second = val[i];
      end
      csr_valid <= 1'b0;
   endtask

   // A good frame with one payload byte of 0xFF
   task automatic test_good_frames();
      send_frame(8'd5, 1'b0, -1, 8'hFF);
   endtask

   // Checksum error and lengths below the overhead
   task automatic test_bad_frames();
      send_frame(8'd5, 1'b1, -1, 8'h00);
      send_frame(8'd0, 1'b0, -1, -1);
      send_frame(8'd3, 1'b0, -1, -1);
   endtask

   // Repeated first header byte, then an empty frame whose checksum carries burst end
   task automatic test_header_restart();
      send_byte(hdr_first, 1'b0);
      send_frame(8'd4, 1'b0, 3, -1);
   endtask

   // Burst end on a lone first header byte and in the middle of the payload
   task automatic test_burst_end();
      send_frame(8'd6, 1'b0, 0, -1);
      send_frame(8'd7, 1'b0, 4, -1);
   endtask

   // Mostly well-formed frames with random content, plus broken headers and noise
   task automatic test_random_traffic(input int n_items);
      int         start;
      int         sel;
      int         pick;
      int         n_bytes;
      logic [7:0] len;
      start = frame_bytes;
      while (frame_bytes - start < n_items) begin
         sel = $urandom_range(99);
         if (sel < 70) begin
            pick = $urandom_range(99);
            if (pick < 6) len = 8'($urandom_range(0, 3));
            else if (pick < 90) len = 8'($urandom_range(4, 12));
            else len = 8'($urandom_range(13, 40));
            n_bytes = (len < FRAME_OVERHEAD) ? 3 : len;
            send_frame(len, $urandom_range(99) < 20,
                       ($urandom_range(99) < 10) ? int'($urandom_range(0, n_bytes - 1)) : -1,
                       -1);
         end else if (sel < 82) begin
            // header start that goes nowhere
            send_byte(hdr_first, 1'b0);
            send_byte(8'($urandom), $urandom_range(99) < 10);
         end else begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), $urandom_range(99) < 10);
         end
      end
   endtask

   // Longest frame: largest payload count
   task automatic test_longest_frame();
      send_frame(8'd255, 1'b0, -1, -1);
   endtask

   // Compare each accepted word against the oldest prediction
   always @(posedge clock) begin : check_words
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         words_seen++;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected word: byte %h pv %b done %b good %b count %0d",
                        $realtime, rsp_word.payload_byte, rsp_word.payload_valid,
                        rsp_word.frame_done, rsp_word.frame_good, rsp_word.payload_count);
         end else begin
            want = expected_words.pop_front();
            if (want.frame_done && want.frame_good) good_frames++;
            else if (want.frame_done) bad_frames++;
            if (rsp_word.payload_byte !== want.payload_byte ||
                rsp_word.payload_valid !== want.payload_valid ||
                rsp_word.frame_done !== want.frame_done ||
                rsp_word.frame_good !== want.frame_good ||
                rsp_word.payload_count !== want.payload_count) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: word mismatch", $realtime);
                  $display("   expected: byte %h pv %b done %b good %b count %0d",
                           want.payload_byte, want.payload_valid, want.frame_done,
                           want.frame_good, want.payload_count);
                  $display("   actual:   byte %h pv %b done %b good %b count %0d",
                           rsp_word.payload_byte, rsp_word.payload_valid,
                           rsp_word.frame_done, rsp_word.frame_good, rsp_word.payload_count);
               end
            end
         end
      end
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Test sequence
   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_HEADER_FIRST;
      csr_wdata <= '0;
      jitter_on = 1'b1;
      hdr_first    = HEADER_FIRST_RESET;
      hdr_second   = HEADER_SECOND_RESET;
      parse_ph     = PH_HUNT;
      frame_len    = '0;
      payload_seen = '0;
      sum_acc      = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset headers
      test_good_frames();
      test_bad_frames();
      test_header_restart();
      test_burst_end();
      test_random_traffic(50);
      wait_for_idle();

      // low/high extremes, no idling on either side
      load_headers(8'h00, 8'hFF);
      jitter_on = 1'b0;
      test_random_traffic(80);
      wait_for_idle();
      jitter_on = 1'b1;

      load_headers(8'hFF, 8'h00);
      test_random_traffic(50);
      wait_for_idle();

      load_headers(8'($urandom), 8'($urandom));
      test_random_traffic(40);
      test_longest_frame();
      wait_for_idle();

      // both header bytes equal
      sel_equal: begin
         logic [7:0] h;
         h = 8'($urandom);
         load_headers(h, h);
      end
      test_random_traffic(40);
      wait_for_idle();

      $display("Sent %0d bytes (%0d inside frames) over five header settings.",
               bytes_sent, frame_bytes);
      $display("Checked %0d result words: %0d good frames, %0d bad or dropped frames.",
               words_seen, good_frames, bad_frames);
      if (mismatches == 0 && expected_words.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
